// ===== rtl/epoch_to_calendar_cron_match_assert.svh =====
// Assertion macros for the epoch to calendar block.
`ifndef EPOCH_TO_CALENDAR_CRON_MATCH_ASSERT_SVH
`define EPOCH_TO_CALENDAR_CRON_MATCH_ASSERT_SVH
`ifndef SYNTH
// Check that b holds in the same cycle as a.
`define E2C_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("e2c assertion failed");
// Check that b holds in the cycle after a.
`define E2C_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("e2c assertion failed");
`else
`define E2C_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define E2C_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/e2c_pkg.sv =====
// Shared types, constants and helpers of the epoch to calendar block.
package e2c_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	localparam logic [CFG_IDX_W-1:0] REG_SECOND_MASK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_MASK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_MASK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH_MASK   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_MASK = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_OFFSET  = 3'd6;

	// Register reset values
	localparam logic [59:0] RST_SECOND_MASK  = {60{1'b1}};
	localparam logic [59:0] RST_MINUTE_MASK  = {60{1'b1}};
	localparam logic [23:0] RST_HOUR_MASK    = 24'hFF_FFFF;
	localparam logic [31:0] RST_DAY_MASK     = 32'hFFFF_FFFE;
	localparam logic [11:0] RST_MONTH_MASK   = 12'hFFF;
	localparam logic [6:0]  RST_WEEKDAY_MASK = 7'h7F;
	localparam logic [16:0] RST_ZONE_OFFSET  = 17'd28800;

	// Serial divider geometry
	localparam int DIV_W   = 33;
	localparam int REM_W   = 11;
	localparam int CNT_W   = 6;

	localparam logic [REM_W-1:0] DIV_SIXTY = 11'd60;
	localparam logic [REM_W-1:0] DIV_DAY   = 11'd24;
	localparam logic [REM_W-1:0] DIV_QUAD  = 11'd1461;
	localparam logic [REM_W-1:0] DIV_WEEK  = 11'd7;

	localparam logic [7:0] BASE_YEAR = 8'd70;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
		logic [CNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [REM_W-1:0] rem;
	} div_rsp_t;

	// Days in each month of a common year, 0 is January
	function automatic logic [4:0] month_len(input logic [3:0] mon);
		logic [4:0] len;
		case (mon)
			4'd1:    len = 5'd28;
			4'd3:    len = 5'd30;
			4'd5:    len = 5'd30;
			4'd8:    len = 5'd30;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/e2c_if.sv =====
// Handshake channels of the epoch to calendar block.
interface e2c_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [4:0] day_of_month;
	logic [3:0] month;
	logic [7:0] year_since_1900;
	logic [2:0] weekday;
	logic       cron_match;

	modport source (output valid, output second, output minute, output hour,
		output day_of_month, output month, output year_since_1900, output weekday,
		output cron_match, input ready);
	modport sink (input valid, input second, input minute, input hour,
		input day_of_month, input month, input year_since_1900, input weekday,
		input cron_match, output ready);
endinterface

interface e2c_cfg_if import e2c_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/e2c_div.sv =====
// Bit-serial restoring divider by a small constant, one quotient bit per cycle.
module e2c_div import e2c_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0] work_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W:0]   trial;
	logic             take;
	logic [REM_W:0]   diff;

	// Shift the next dividend bit into the partial remainder and try the subtract
	always_comb begin
		trial = {rem_q, work_q[DIV_W-1]};
		take  = trial >= {1'b0, divisor_q};
		diff  = trial - {1'b0, divisor_q};
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance the dividend and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], take};
			rem_q  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = work_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/epoch_to_calendar_cron_match.sv =====
// Epoch seconds to calendar fields converter with cron mask match.
//
//  channel   dir  modport  word
//  epoch     in   sink     epoch_seconds
//  calendar  out  source   second .. weekday, cron_match
//  cfg       in   sink     index, data (register write)
//
// One word, accept to next accept, runs five bit-serial divider passes of 33, 27,
// 22, 17 and 18 quotient bits, each followed by a handover, then 1 to 4 year steps,
// a leap-day check, up to 12 month steps, the store and idle.
// Reset clears the control state and loads the register reset values.
// The store waits while the output register holds an untaken word; the next word
// is accepted once the store is done. Register writes are always taken.
`include "epoch_to_calendar_cron_match_assert.svh"

module epoch_to_calendar_cron_match import e2c_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	e2c_in_if.sink   epoch,
	e2c_out_if.source calendar,
	e2c_cfg_if.sink  cfg
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SEC  = 4'd1;
	localparam logic [3:0] S_MIN  = 4'd2;
	localparam logic [3:0] S_HOUR = 4'd3;
	localparam logic [3:0] S_QUAD = 4'd4;
	localparam logic [3:0] S_WDAY = 4'd5;
	localparam logic [3:0] S_YEAR = 4'd6;
	localparam logic [3:0] S_FEB  = 4'd7;
	localparam logic [3:0] S_MON  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [59:0] second_mask_q;
	logic [59:0] minute_mask_q;
	logic [23:0] hour_mask_q;
	logic [31:0] day_mask_q;
	logic [11:0] month_mask_q;
	logic [6:0]  weekday_mask_q;
	logic [16:0] zone_q;

	logic [3:0]  state_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [16:0] days_q;
	logic [10:0] dq_q;
	logic [7:0]  year_q;
	logic [2:0]  wday_q;
	logic [8:0]  doy_q;
	logic [3:0]  mon_q;
	logic [4:0]  mday_q;

	logic        out_valid_q;
	logic [5:0]  out_sec_q;
	logic [5:0]  out_min_q;
	logic [4:0]  out_hour_q;
	logic [4:0]  out_mday_q;
	logic [3:0]  out_mon_q;
	logic [7:0]  out_year_q;
	logic [2:0]  out_wday_q;
	logic        out_match_q;

	div_req_t    div_req;
	div_rsp_t    div_rsp;

	logic        in_fire;
	logic        out_load;
	logic signed [33:0] local_sum;
	logic [32:0] local_time;
	logic        leap;
	logic [10:0] year_span;
	logic [4:0]  cur_len;
	logic [63:0] sec_mask_ext;
	logic [63:0] min_mask_ext;
	logic [31:0] hour_mask_ext;
	logic [15:0] mon_mask_ext;
	logic [7:0]  wday_mask_ext;
	logic        match;
	logic        div_phase;
	logic        out_in_range;

	assign in_fire     = epoch.valid && epoch.ready;
	assign epoch.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign out_load    = (state_q == S_OUT) && (!out_valid_q || calendar.ready);

	// Add the zone offset and clamp negative local time to zero
	always_comb begin
		local_sum  = $signed({2'b00, epoch.epoch_seconds}) +
			$signed({{17{zone_q[16]}}, zone_q});
		local_time = local_sum[33] ? '0 : local_sum[32:0];
	end

	// Year and month walk helpers
	always_comb begin
		leap      = (year_q[1:0] == 2'b00);
		year_span = leap ? 11'd366 : 11'd365;
		cur_len   = month_len(mon_q);
	end

	// Look up each field in its mask
	always_comb begin
		sec_mask_ext  = {4'b0, second_mask_q};
		min_mask_ext  = {4'b0, minute_mask_q};
		hour_mask_ext = {8'b0, hour_mask_q};
		mon_mask_ext  = {4'b0, month_mask_q};
		wday_mask_ext = {1'b0, weekday_mask_q};
		match = sec_mask_ext[sec_q] && min_mask_ext[min_q] && hour_mask_ext[hour_q] &&
			day_mask_q[mday_q] && mon_mask_ext[mon_q] && wday_mask_ext[wday_q];
	end

	// Issue the divider passes: seconds, minutes, hours, four-year blocks, weekday
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = DIV_SIXTY;
		div_req.nbits    = CNT_W'(DIV_W);
		case (state_q)
			S_IDLE: begin
				div_req.start    = in_fire;
				div_req.dividend = local_time;
			end
			S_SEC: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {div_rsp.quot[26:0], 6'b0};
				div_req.nbits    = CNT_W'(27);
			end
			S_MIN: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {div_rsp.quot[21:0], 11'b0};
				div_req.divisor  = DIV_DAY;
				div_req.nbits    = CNT_W'(22);
			end
			S_HOUR: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {div_rsp.quot[16:0], 16'b0};
				div_req.divisor  = DIV_QUAD;
				div_req.nbits    = CNT_W'(17);
			end
			S_QUAD: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {({1'b0, days_q} + 18'd4), 15'b0};
				div_req.divisor  = DIV_WEEK;
				div_req.nbits    = CNT_W'(18);
			end
			default: begin
			end
		endcase
	end

	e2c_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_mask_q  <= RST_SECOND_MASK;
			minute_mask_q  <= RST_MINUTE_MASK;
			hour_mask_q    <= RST_HOUR_MASK;
			day_mask_q     <= RST_DAY_MASK;
			month_mask_q   <= RST_MONTH_MASK;
			weekday_mask_q <= RST_WEEKDAY_MASK;
			zone_q         <= RST_ZONE_OFFSET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SECOND_MASK:  second_mask_q  <= cfg.data[59:0];
				REG_MINUTE_MASK:  minute_mask_q  <= cfg.data[59:0];
				REG_HOUR_MASK:    hour_mask_q    <= cfg.data[23:0];
				REG_DAY_MASK:     day_mask_q     <= cfg.data[31:0];
				REG_MONTH_MASK:   month_mask_q   <= cfg.data[11:0];
				REG_WEEKDAY_MASK: weekday_mask_q <= cfg.data[6:0];
				REG_ZONE_OFFSET:  zone_q         <= cfg.data[16:0];
				default: begin
				end
			endcase
		end
	end

	// Sequence the conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_SEC;
				S_SEC:  if (div_rsp.done) state_q <= S_MIN;
				S_MIN:  if (div_rsp.done) state_q <= S_HOUR;
				S_HOUR: if (div_rsp.done) state_q <= S_QUAD;
				S_QUAD: if (div_rsp.done) state_q <= S_WDAY;
				S_WDAY: if (div_rsp.done) state_q <= S_YEAR;
				S_YEAR: if (dq_q < year_span) state_q <= S_FEB;
				S_FEB: begin
					if (leap && doy_q == 9'd60) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MON;
					end
				end
				S_MON: begin
					if (!(mon_q < 4'd11 && {4'b0, cur_len} < doy_q)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT:   if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture remainders and walk years and months
	always_ff @(posedge clk) begin
		case (state_q)
			S_SEC:  if (div_rsp.done) sec_q <= div_rsp.rem[5:0];
			S_MIN:  if (div_rsp.done) min_q <= div_rsp.rem[5:0];
			S_HOUR: begin
				if (div_rsp.done) begin
					hour_q <= div_rsp.rem[4:0];
					days_q <= div_rsp.quot[16:0];
				end
			end
			S_QUAD: begin
				if (div_rsp.done) begin
					dq_q   <= div_rsp.rem;
					year_q <= BASE_YEAR + {div_rsp.quot[5:0], 2'b00};
				end
			end
			S_WDAY: if (div_rsp.done) wday_q <= div_rsp.rem[2:0];
			S_YEAR: begin
				if (dq_q >= year_span) begin
					dq_q   <= dq_q - year_span;
					year_q <= year_q + 8'd1;
				end else begin
					doy_q <= dq_q[8:0] + 9'd1;
				end
			end
			S_FEB: begin
				if (leap && doy_q == 9'd60) begin
					mon_q  <= 4'd1;
					mday_q <= 5'd29;
				end else begin
					mon_q <= 4'd0;
					if (leap && doy_q > 9'd60) doy_q <= doy_q - 9'd1;
				end
			end
			S_MON: begin
				if (mon_q < 4'd11 && {4'b0, cur_len} < doy_q) begin
					doy_q <= doy_q - {4'b0, cur_len};
					mon_q <= mon_q + 4'd1;
				end else begin
					mday_q <= doy_q[4:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the finished word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (calendar.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sec_q   <= sec_q;
			out_min_q   <= min_q;
			out_hour_q  <= hour_q;
			out_mday_q  <= mday_q;
			out_mon_q   <= mon_q;
			out_year_q  <= year_q;
			out_wday_q  <= wday_q;
			out_match_q <= match;
		end
	end

	assign calendar.valid           = out_valid_q;
	assign calendar.second          = out_sec_q;
	assign calendar.minute          = out_min_q;
	assign calendar.hour            = out_hour_q;
	assign calendar.day_of_month    = out_mday_q;
	assign calendar.month           = out_mon_q;
	assign calendar.year_since_1900 = out_year_q;
	assign calendar.weekday         = out_wday_q;
	assign calendar.cron_match      = out_match_q;

	// Flag the divide states and a delivered word inside the calendar ranges
	assign div_phase = (state_q == S_SEC) || (state_q == S_MIN) || (state_q == S_HOUR) ||
		(state_q == S_QUAD) || (state_q == S_WDAY);
	assign out_in_range = (calendar.second < 6'd60) && (calendar.minute < 6'd60) &&
		(calendar.hour < 5'd24) && (calendar.month < 4'd12) &&
		(calendar.weekday < 3'd7) && (calendar.day_of_month != 5'd0);

	// An accepted word starts the divider sequence
	`E2C_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_fire, state_q == S_SEC)
	// The divider only finishes while a divide pass is expected
	`E2C_ASSERT_IMPLIES(a_div_done_phase, clk, arst_n, div_rsp.done, div_phase)
	// Delivered fields stay inside their calendar ranges
	`E2C_ASSERT_IMPLIES(a_out_ranges, clk, arst_n, calendar.valid, out_in_range)

endmodule

// ===== test/epoch_to_calendar_cron_match_test.sv =====
// Testbench for the epoch seconds to calendar converter with cron mask match.
`timescale 1ns / 100ps

module epoch_to_calendar_cron_match_test import e2c_pkg::*;;

	localparam int          MAX_REPORTS       = 10;
	localparam int          HOLD_OFF_CYCLES   = 1500;
	localparam int          SETTLE_CYCLES     = 300;
	localparam int          RANDOM_PER_PHASE  = 330;
	localparam int          PHASE_COUNT       = 6;
	localparam longint      TIMEOUT_NS        = 10_000_000;
	localparam int          ZONE_LIMIT        = 50400;
	localparam longint      SECONDS_PER_DAY   = 86400;
	localparam longint      QUAD_HOURS        = 1461 * 24;
	localparam int          COMMON_YEAR_HOURS = 8760;
	localparam int          EPOCH_YEAR        = 70;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [7:0] year_since_1900;
		logic [2:0] weekday;
		logic       cron_match;
	} calendar_t;

	logic clk;
	logic arst_n;

	e2c_in_if  epoch_ch ();
	e2c_out_if cal_ch ();
	e2c_cfg_if cfg_ch ();

	epoch_to_calendar_cron_match u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.epoch    (epoch_ch),
		.calendar (cal_ch),
		.cfg      (cfg_ch)
	);

	// Local copy of the register file
	logic [59:0] allow_second;
	logic [59:0] allow_minute;
	logic [23:0] allow_hour;
	logic [31:0] allow_day;
	logic [11:0] allow_month;
	logic [6:0]  allow_weekday;
	logic [16:0] zone_reg;

	calendar_t pending_calendar [$];
	calendar_t checked_want;
	int        mismatch_count;
	bit        gaps_enabled;
	int        burst_left;
	bit        hold_off_request;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int month_days(input int mon);
		if (mon == 1)
			return 28;
		return (mon == 3 || mon == 5 || mon == 8 || mon == 10) ? 30 : 31;
	endfunction

	// Convert one epoch word to calendar fields under the current settings
	function automatic calendar_t predict_calendar(input logic [31:0] stamp);
		calendar_t res;
		longint    zone_s;
		longint    total;
		int        sec, mins, hr, wday, yr, span, doy, mon;
		bit        leap;
		zone_s = $signed(zone_reg);
		total = {32'd0, stamp};
		total = total + zone_s;
		if (total < 0)
			total = 0;
		sec = int'(total % 60);
		total = total / 60;
		mins = int'(total % 60);
		total = total / 60;
		wday = int'((total / 24 + 4) % 7);
		yr = int'(total / QUAD_HOURS) * 4 + EPOCH_YEAR;
		total = total % QUAD_HOURS;
		// walk the years of the four-year block
		while (1) begin
			span = COMMON_YEAR_HOURS + (((yr & 3) == 0) ? 24 : 0);
			if (total < span)
				break;
			yr++;
			total = total - span;
		end
		hr = int'(total % 24);
		doy = int'(total / 24) + 1;
		leap = ((yr & 3) == 0);
		mon = 0;
		if (leap && doy == 60) begin
			mon = 1;
			doy = 29;
		end else begin
			if (leap && doy > 60)
				doy--;
			while (mon < 11 && month_days(mon) < doy) begin
				doy = doy - month_days(mon);
				mon++;
			end
		end
		res.second          = sec[5:0];
		res.minute          = mins[5:0];
		res.hour            = hr[4:0];
		res.day_of_month    = doy[4:0];
		res.month           = mon[3:0];
		res.year_since_1900 = yr[7:0];
		res.weekday         = wday[2:0];
		res.cron_match      = allow_second[sec] && allow_minute[mins] && allow_hour[hr] &&
			allow_day[doy] && allow_month[mon] && allow_weekday[wday];
		return res;
	endfunction

	function automatic void note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", what);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want)
			note_mismatch($sformatf("calendar %s mismatch: expected %0d, got %0d at %0t ns",
				name, want, got, $time));
	endfunction

	function automatic logic [59:0] random_word60();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[59:0];
	endfunction

	// Most bits set, so that the match flag comes out both ways
	function automatic logic [59:0] dense_mask();
		return random_word60() | random_word60() | random_word60();
	endfunction

	// Zone offset in the low bits, noise above the register width
	function automatic logic [59:0] zone_word(input int zone);
		logic [59:0] w;
		w = random_word60();
		w[16:0] = zone[16:0];
		return w;
	endfunction

	function automatic logic [31:0] pick_epoch();
		int unsigned sel;
		longint      stamp;
		longint      zone_s;
		int          jitter;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return $urandom;
		if (sel < 8)
			return $urandom_range(0, 200000);
		// land near a local midnight
		zone_s = $signed(zone_reg);
		jitter = int'($urandom_range(0, 4)) - 2;
		stamp = longint'($urandom_range(0, 49710)) * SECONDS_PER_DAY - zone_s + jitter;
		if (stamp < 0)
			stamp = 0;
		if (stamp > 64'd4294967295)
			stamp = 64'd4294967295;
		return stamp[31:0];
	endfunction

	// Write one register; valid stays high for a following write
	task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= reg_index;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		case (reg_index)
			REG_SECOND_MASK:  allow_second  = value[59:0];
			REG_MINUTE_MASK:  allow_minute  = value[59:0];
			REG_HOUR_MASK:    allow_hour    = value[23:0];
			REG_DAY_MASK:     allow_day     = value[31:0];
			REG_MONTH_MASK:   allow_month   = value[11:0];
			REG_WEEKDAY_MASK: allow_weekday = value[6:0];
			REG_ZONE_OFFSET:  zone_reg      = value[16:0];
			default: ;
		endcase
	endtask

	// Load every register, then poke the unused index, which must be ignored
	task automatic load_settings(input logic [59:0] sec_m, input logic [59:0] min_m,
		input logic [59:0] hour_m, input logic [59:0] day_m, input logic [59:0] mon_m,
		input logic [59:0] wday_m, input logic [59:0] zone_w);
		write_register(REG_SECOND_MASK, sec_m);
		write_register(REG_MINUTE_MASK, min_m);
		write_register(REG_HOUR_MASK, hour_m);
		write_register(REG_DAY_MASK, day_m);
		write_register(REG_MONTH_MASK, mon_m);
		write_register(REG_WEEKDAY_MASK, wday_m);
		write_register(REG_ZONE_OFFSET, zone_w);
		write_register(REG_UNUSED, random_word60());
		cfg_ch.valid <= 1'b0;
	endtask

	// Offer one epoch word and record its calendar once accepted
	task automatic offer_epoch(input logic [31:0] stamp);
		calendar_t   want;
		int unsigned gap;
		want = predict_calendar(stamp);
		epoch_ch.valid         <= 1'b1;
		epoch_ch.epoch_seconds <= stamp;
		@(posedge clk);
		while (epoch_ch.ready !== 1'b1)
			@(posedge clk);
		pending_calendar.push_back(want);
		if (gaps_enabled) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) :
					$urandom_range(1, 8);
				epoch_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
		end
	endtask

	// Drop valid and wait until every calendar word is back
	task automatic quiesce();
		epoch_ch.valid <= 1'b0;
		while (pending_calendar.size() != 0)
			@(posedge clk);
	endtask

	// Year, month and leap-day boundaries under the reset settings
	task automatic test_calendar_edges();
		offer_epoch(32'd0);
		offer_epoch(32'hFFFF_FFFF);
		offer_epoch(32'd946655999);
		offer_epoch(32'd951753600);
		offer_epoch(32'd951839999);
		offer_epoch(32'd951840000);
		offer_epoch(32'd4102415999);
		offer_epoch(32'd4107513600);
		offer_epoch(32'd4107599999);
		quiesce();
	endtask

	// Single-bit masks, bits above each width, clamping and offset extremes
	task automatic test_register_writes();
		load_settings(60'h1, 60'h1, 60'hFFF_FFFF_FF00_0001, 60'hFFF_FFFF_0000_0002,
			60'hFFF_FFFF_FFFF_F001, 60'hFFF_FFFF_FFFF_FF90, 60'hFFF_FFFF_FFFE_0000);
		offer_epoch(32'd0);
		offer_epoch(32'd1);
		offer_epoch(32'd60);
		quiesce();
		load_settings(60'h0, 60'h0, 60'h0, 60'h0, 60'h0, 60'h0, 60'h0_0001_0000);
		offer_epoch(32'd0);
		offer_epoch(32'd65535);
		offer_epoch(32'd65536);
		offer_epoch(32'd65537);
		quiesce();
		load_settings({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}},
			{60{1'b1}}, 60'h0_0000_FFFF);
		offer_epoch(32'hFFFF_FFFF);
		offer_epoch(32'hFFFF_0000);
		quiesce();
		load_settings({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}},
			{60{1'b1}}, zone_word(-ZONE_LIMIT));
		offer_epoch(32'd50399);
		offer_epoch(32'd50400);
		quiesce();
		load_settings({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}},
			{60{1'b1}}, zone_word(ZONE_LIMIT));
		offer_epoch(32'hFFFF_FFFF);
		quiesce();
	endtask

	// Hold the output off long enough that the input backs up
	task automatic test_output_backpressure();
		int n;
		gaps_enabled = 1'b0;
		hold_off_request = 1'b1;
		for (n = 0; n < 8; n++)
			offer_epoch($urandom);
		quiesce();
		gaps_enabled = 1'b1;
	endtask

	// Random words under a series of settings, extremes among them
	task automatic test_random_settings();
		int phase;
		int n;
		int zone;
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: load_settings({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}},
					{60{1'b1}}, {60{1'b1}}, zone_word(0));
				1: load_settings(dense_mask(), dense_mask(), dense_mask(), dense_mask(),
					dense_mask(), dense_mask(), zone_word(-ZONE_LIMIT));
				2: load_settings(dense_mask(), dense_mask(), dense_mask(), dense_mask(),
					dense_mask(), dense_mask(), zone_word(ZONE_LIMIT));
				3: load_settings(60'h0, 60'h0, 60'h0, 60'h0, 60'h0, 60'h0,
					zone_word(-65536));
				4: load_settings(dense_mask(), dense_mask(), dense_mask(), dense_mask(),
					dense_mask(), dense_mask(), zone_word(65535));
				default: begin
					zone = int'($urandom_range(0, 2 * ZONE_LIMIT)) - ZONE_LIMIT;
					load_settings(random_word60(), random_word60(), random_word60(),
						random_word60(), random_word60(), random_word60(), zone_word(zone));
				end
			endcase
			// run the first phase back to back
			gaps_enabled = (phase != 0);
			for (n = 0; n < RANDOM_PER_PHASE; n++)
				offer_epoch(pick_epoch());
			quiesce();
		end
		gaps_enabled = 1'b1;
	endtask

	// Receiver: run free or stall on a rotating pattern, or hold off on request
	initial begin : calendar_sink
		int unsigned mode_left;
		bit          free_run;
		logic [15:0] stall_bits;
		int          held;
		cal_ch.ready = 1'b0;
		mode_left = 0;
		free_run = 1'b1;
		stall_bits = 16'hFFFF;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				cal_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_OFF_CYCLES; held++)
					@(posedge clk);
			end else begin
				if (mode_left == 0) begin
					free_run = ($urandom_range(0, 2) == 0);
					stall_bits = 16'($urandom);
					stall_bits[0] = 1'b1;
					mode_left = $urandom_range(50, 400);
				end
				mode_left--;
				cal_ch.ready <= free_run | stall_bits[0];
				stall_bits = {stall_bits[0], stall_bits[15:1]};
			end
		end
	end

	// Compare each calendar word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n === 1'b1 && cal_ch.valid === 1'b1 && cal_ch.ready === 1'b1) begin
			if (pending_calendar.size() == 0) begin
				note_mismatch($sformatf("calendar word with nothing expected at %0t ns", $time));
			end else begin
				checked_want = pending_calendar.pop_front();
				check_field("second", checked_want.second, cal_ch.second);
				check_field("minute", checked_want.minute, cal_ch.minute);
				check_field("hour", checked_want.hour, cal_ch.hour);
				check_field("day_of_month", checked_want.day_of_month, cal_ch.day_of_month);
				check_field("month", checked_want.month, cal_ch.month);
				check_field("year_since_1900", checked_want.year_since_1900,
					cal_ch.year_since_1900);
				check_field("weekday", checked_want.weekday, cal_ch.weekday);
				check_field("cron_match", checked_want.cron_match, cal_ch.cron_match);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("epoch_to_calendar_cron_match test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		epoch_ch.valid = 1'b0;
		epoch_ch.epoch_seconds = 32'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SECOND_MASK;
		cfg_ch.data = '0;
		allow_second = RST_SECOND_MASK;
		allow_minute = RST_MINUTE_MASK;
		allow_hour = RST_HOUR_MASK;
		allow_day = RST_DAY_MASK;
		allow_month = RST_MONTH_MASK;
		allow_weekday = RST_WEEKDAY_MASK;
		zone_reg = RST_ZONE_OFFSET;
		mismatch_count = 0;
		gaps_enabled = 1'b1;
		burst_left = 0;
		hold_off_request = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_calendar_edges();
		test_register_writes();
		test_output_backpressure();
		test_random_settings();

		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_calendar.size() == 0)
			$display("epoch_to_calendar_cron_match test passed");
		else
			$display("epoch_to_calendar_cron_match test failed");
		$finish;
	end

endmodule

// ===== epoch_to_calendar_cron_match.f =====
+incdir+rtl
rtl/e2c_pkg.sv
rtl/e2c_if.sv
rtl/e2c_div.sv
rtl/epoch_to_calendar_cron_match.sv
test/epoch_to_calendar_cron_match_test.sv
